### hw/rtl/rbb_pkg.sv
package rbb_pkg;

  localparam int BYTE_W    = 8;
  localparam int CAP_W     = 10;
  localparam int CNT_W     = 10;
  localparam int MODE_W    = 2;
  localparam int S_DATA_W  = 24;  // data_in, length, zero pad
  localparam int M_DATA_W  = 40;  // data_out, moved, data_count, free_count, zero pad

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_ERASE = 2'd3
  } rbb_mode_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture the incoming word
    logic exec;         // clamp the request, do a put
    logic adv;          // move the read index past an erased run
    logic rd;           // read one run byte from the ring
    logic load_single;  // load the one-word result of put, erase or empty run
    logic load_byte;    // load a run byte as a result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    rbb_mode_e mode;
    logic      n_zero;     // clamped run length is zero (valid during exec)
    logic      last_byte;  // run byte just read is the final one
    logic      out_free;   // output register can take a word this cycle
  } status_t;

endpackage

### hw/rtl/rbb_ram.sv
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rbb_ctrl.sv
module rbb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  rbb_pkg::status_t status_i,
  output rbb_pkg::cmd_t    cmd_o
);
  import rbb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_ADV    = 6'b000100,
    ST_RESULT = 6'b001000,
    ST_RD     = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.mode)
          MODE_PUT:   state_d = ST_RESULT;
          MODE_ERASE: state_d = ST_ADV;
          default:    state_d = status_i.n_zero ? ST_RESULT : ST_RD;
        endcase
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d         = status_i.last_byte ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_single || cmd_o.load_byte) |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_rd_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_EMIT))
    else $error("ring read not followed by emit");

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (cmd_o.exec && !s_tready_o))
    else $error("accepted word not executed next cycle");

endmodule

### hw/rtl/rbb_datapath.sv
module rbb_datapath #(
  parameter int DEPTH   = 1024,
  parameter int MAX_RUN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbb_pkg::cmd_t                cmd_i,
  output rbb_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [rbb_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic [rbb_pkg::S_DATA_W-1:0] s_tdata_i,
  input  logic [rbb_pkg::MODE_W-1:0]   s_tuser_i,
  output logic [rbb_pkg::M_DATA_W-1:0] m_tdata_o,
  output logic                         m_tuser_o,
  output logic                         m_tlast_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i
);
  import rbb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int NW = (AW > CNT_W) ? AW : CNT_W;
  localparam int KW = $clog2(MAX_RUN + 1);
  localparam int CW = (AW > KW) ? AW : KW;

  // control state
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [AW-1:0]    wi_q, wi_d;
  logic [AW-1:0]    ri_q, ri_d;
  logic [KW-1:0]    k_q, k_d;
  logic             out_valid_q, out_valid_d;

  // payload
  rbb_mode_e        mode_q;
  logic [BYTE_W-1:0] din_q;
  logic [CNT_W-1:0] len_q;
  logic [AW-1:0]    n_q;
  logic [AW-1:0]    cur_q;
  logic [BYTE_W-1:0] out_data_q;
  logic             out_bv_q;
  logic             out_last_q;
  logic [CNT_W-1:0] out_moved_q;
  logic [CNT_W-1:0] out_dc_q;
  logic [CNT_W-1:0] out_fc_q;

  logic [SW-1:0]    slots;
  logic [AW-1:0]    held;
  logic [AW-1:0]    room;
  logic [AW-1:0]    wi_inc;
  logic [AW-1:0]    cur_inc;
  logic [SW-1:0]    ri_sum;
  logic [AW-1:0]    ri_adv;
  logic [NW-1:0]    lim;
  logic [AW-1:0]    n_calc;
  logic             put_ok;
  logic [BYTE_W-1:0] rdata;

  // ring size: capacity saturates at DEPTH-1, one slot always stays empty
  always_comb begin
    if (int'(cap_q) > DEPTH - 1) begin
      slots = SW'(DEPTH);
    end else begin
      slots = SW'(cap_q) + SW'(1);
    end
  end

  always_comb begin
    if (wi_q >= ri_q) begin
      held = AW'(SW'(wi_q) - SW'(ri_q));
    end else begin
      held = AW'(slots - SW'(ri_q) + SW'(wi_q));
    end
  end

  assign room   = AW'(slots - SW'(1) - SW'(held));
  assign put_ok = (room != '0);

  assign wi_inc  = ((SW'(wi_q) + SW'(1)) == slots) ? '0 : AW'(SW'(wi_q) + SW'(1));
  assign cur_inc = ((SW'(cur_q) + SW'(1)) == slots) ? '0 : AW'(SW'(cur_q) + SW'(1));

  // erase run is at most held, so one wrap is enough
  assign ri_sum = SW'(ri_q) + SW'(n_q);
  assign ri_adv = (ri_sum >= slots) ? AW'(ri_sum - slots) : AW'(ri_sum);

  always_comb begin
    lim = NW'(len_q);
    if (mode_q != MODE_ERASE && lim > NW'(MAX_RUN)) begin
      lim = NW'(MAX_RUN);
    end
    if (lim > NW'(held)) begin
      lim = NW'(held);
    end
    n_calc = AW'(lim);
  end

  always_comb begin
    cap_d = cap_q;
    wi_d  = wi_q;
    ri_d  = ri_q;
    k_d   = k_q;
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
      wi_d  = '0;
      ri_d  = '0;
    end else begin
      if (cmd_i.exec && mode_q == MODE_PUT && put_ok) begin
        wi_d = wi_inc;
      end
      if (cmd_i.adv) begin
        ri_d = ri_adv;
      end
      if (cmd_i.rd && mode_q == MODE_GET) begin
        ri_d = cur_inc;
      end
    end
    if (cmd_i.exec) begin
      k_d = '0;
    end else if (cmd_i.rd) begin
      k_d = k_q + KW'(1);
    end
  end

  always_comb begin
    if (cmd_i.load_single || cmd_i.load_byte) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      wi_q        <= '0;
      ri_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= rbb_mode_e'(s_tuser_i);
      din_q  <= s_tdata_i[BYTE_W-1:0];
      len_q  <= s_tdata_i[BYTE_W+CNT_W-1:BYTE_W];
    end
    if (cmd_i.exec) begin
      n_q   <= (mode_q == MODE_PUT) ? AW'(put_ok) : n_calc;
      cur_q <= ri_q;
    end else if (cmd_i.rd) begin
      cur_q <= cur_inc;
    end
    if (cmd_i.load_single) begin
      out_data_q  <= '0;
      out_bv_q    <= 1'b0;
      out_last_q  <= 1'b1;
      out_moved_q <= CNT_W'(n_q);
      out_dc_q    <= CNT_W'(held);
      out_fc_q    <= CNT_W'(room);
    end else if (cmd_i.load_byte) begin
      out_data_q  <= rdata;
      out_bv_q    <= 1'b1;
      out_last_q  <= status_o.last_byte;
      out_moved_q <= CNT_W'(k_q);
      out_dc_q    <= CNT_W'(held);
      out_fc_q    <= CNT_W'(room);
    end
  end

  rbb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && mode_q == MODE_PUT && put_ok),
    .waddr_i(wi_q),
    .wdata_i(din_q),
    .re_i   (cmd_i.rd),
    .raddr_i(cur_q),
    .rdata_o(rdata)
  );

  assign status_o.mode      = mode_q;
  assign status_o.n_zero    = (n_calc == '0);
  assign status_o.last_byte = (CW'(k_q) == CW'(n_q));
  assign status_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_bv_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {2'b00, out_fc_q, out_dc_q, out_moved_q, out_data_q};

  a_index_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(wi_q) < slots) && (SW'(ri_q) < slots))
    else $error("ring index outside active slots");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(k_q) <= MAX_RUN)
    else $error("run counter beyond MAX_RUN");

  a_put_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && mode_q == MODE_PUT && put_ok && !cfg_we_i) |=> (wi_q != $past(wi_q)))
    else $error("accepted put did not advance write index");

endmodule

### hw/rtl/ring_byte_buffer.sv
// Channel  Dir  Fields (low bit up)
// s_axis   in   tuser: mode[1:0]; tdata: data_in[7:0], length[17:8], pad[23:18]
// m_axis   out  tuser: byte_valid; tlast: last;
//               tdata: data_out[7:0], moved[17:8], data_count[27:18],
//               free_count[37:28], pad[39:38]
// cfg      in   cfg_we_i, cfg_wdata_i: capacity[9:0]
//
// Sequence: put and an empty get/peek pass through EXEC and RESULT, erase through
// EXEC, ADV and RESULT; the single result loads in RESULT once the output register
// is free. A get/peek run of n bytes passes EXEC, then one ring read and one emit per byte,
// set by the registered read port of the ring RAM.
// Reset: both indices zero, capacity 1023, no result pending.
// Stalls: one output register; a held result blocks only the next result load,
// and a new word is taken as soon as the previous one has loaded its last result.
module ring_byte_buffer #(
  parameter int DEPTH   = 1024,
  parameter int MAX_RUN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config: capacity, write empties the ring
  input  logic                         cfg_we_i,
  input  logic [rbb_pkg::CAP_W-1:0]    cfg_wdata_i,
  // request words
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rbb_pkg::S_DATA_W-1:0] s_axis_tdata,   // data_in, length, pad
  input  logic [rbb_pkg::MODE_W-1:0]   s_axis_tuser,   // mode
  // result words
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rbb_pkg::M_DATA_W-1:0] m_axis_tdata,   // data_out, moved, data_count,
                                                       // free_count, pad
  output logic                         m_axis_tuser,   // byte_valid
  output logic                         m_axis_tlast    // last word of the request
);
  import rbb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one request at a time
  rbb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // indices, clamping, ring RAM and output register
  rbb_datapath #(
    .DEPTH  (DEPTH),
    .MAX_RUN(MAX_RUN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready)
  );

endmodule
